@@ rtl/lpbu_pkg.sv @@
package lpbu_pkg;

    localparam int unsigned BRIGHT_W   = 8;
    localparam int unsigned COLOR_W    = 4;
    localparam int unsigned CHAN_W     = 8;
    localparam int unsigned INDEX_W    = 5;
    localparam int unsigned TOTAL_W    = 6;
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 8;
    localparam int unsigned COUNT_W    = 5;
    localparam int unsigned MODE_W     = 2;

    localparam logic [CFG_ADDR_W-1:0] REG_DISPLAY_COLOR  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_INTERNAL_COLOR = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_INTERNAL_LEVEL = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_INTERNAL_MODE  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_BACKLIGHT_LEDS = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_INTERNAL_LEDS  = 3'd5;

    localparam logic [MODE_W-1:0] MODE_ALWAYS = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ON     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_AUTO   = 2'd2;

    localparam logic KIND_WRITE   = 1'b0;
    localparam logic KIND_REFRESH = 1'b1;

    localparam logic [BRIGHT_W-1:0] PREV_LEVEL_RST = 8'd123;
    localparam logic [COLOR_W-1:0]  PREV_COLOR_RST = 4'd15;
    localparam logic [COUNT_W-1:0]  BACKLIGHT_RST  = 5'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_CALC,
        S_BACKLIGHT,
        S_INTERNAL,
        S_REFRESH
    } state_t;

    typedef logic [23:0] rgb_t;

    function automatic rgb_t palette_rgb(input logic [COLOR_W-1:0] idx);
        rgb_t c;
        case (idx)
            4'd0:    c = {8'd255, 8'd79,  8'd0};
            4'd1:    c = {8'd255, 8'd170, 8'd0};
            4'd2:    c = {8'd167, 8'd255, 8'd0};
            4'd3:    c = {8'd0,   8'd255, 8'd0};
            4'd4:    c = {8'd0,   8'd255, 8'd127};
            4'd5:    c = {8'd0,   8'd210, 8'd210};
            4'd6:    c = {8'd0,   8'd127, 8'd255};
            4'd7:    c = {8'd0,   8'd0,   8'd255};
            4'd8:    c = {8'd127, 8'd0,   8'd255};
            4'd9:    c = {8'd210, 8'd0,   8'd210};
            4'd10:   c = {8'd255, 8'd0,   8'd127};
            4'd11:   c = {8'd255, 8'd0,   8'd0};
            4'd12:   c = {8'd140, 8'd140, 8'd140};
            default: c = 24'd0;
        endcase
        return c;
    endfunction

endpackage

@@ rtl/lpbu_item_if.sv @@
interface lpbu_item_if;
    logic                          valid;
    logic                          ready;
    logic [lpbu_pkg::BRIGHT_W-1:0] brightness;

    modport source (output valid, output brightness, input ready);
    modport sink (input valid, input brightness, output ready);
endinterface

@@ rtl/lpbu_result_if.sv @@
interface lpbu_result_if;
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic [lpbu_pkg::INDEX_W-1:0] led_index;
    logic [lpbu_pkg::CHAN_W-1:0]  red;
    logic [lpbu_pkg::CHAN_W-1:0]  green;
    logic [lpbu_pkg::CHAN_W-1:0]  blue;
    logic [lpbu_pkg::TOTAL_W-1:0] led_total;
    logic                         last;

    modport source (output valid, output kind, output led_index, output red, output green,
                    output blue, output led_total, output last, input ready);
    modport sink (input valid, input kind, input led_index, input red, input green,
                  input blue, input led_total, input last, output ready);
endinterface

@@ rtl/lpbu_cfg_if.sv @@
interface lpbu_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [lpbu_pkg::CFG_ADDR_W-1:0] index;
    logic [lpbu_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/lpbu_scale.sv @@
module lpbu_scale (
    input  logic                         clk,
    input  logic [lpbu_pkg::CHAN_W-1:0]  p,
    input  logic [lpbu_pkg::CHAN_W-1:0]  lvl,
    output logic [lpbu_pkg::CHAN_W-1:0]  q
);

    logic [15:0] prod_reg;
    logic [16:0] sum;

    always_ff @(posedge clk)
    begin
        prod_reg <= 16'(p) * 16'(lvl);
    end

    // floor(x / 255) for x up to 255*255
    assign sum = {1'b0, prod_reg} + 17'd1 + {9'd0, prod_reg[15:8]};
    assign q   = sum[15:8];

endmodule

@@ rtl/led_palette_brightness_update_core.sv @@
// channel | dir | beat contents
// --------+-----+--------------------------------------------------------
// item    | in  | brightness
// result  | out | kind, led_index, red, green, blue, led_total, last
// cfg     | in  | index, data (register write)
//
// An item that changes nothing returns to idle from the check step. Otherwise the
// check step is followed by six channel levels on the shared multiply/scale unit,
// then the LED writes, one per cycle while the result channel accepts them, and
// the refresh beat. Result back-pressure stalls the sequencer in place.
// Reset restores default settings, forgets the applied history; no clearing pass.
module led_palette_brightness_update_core #(
    parameter int unsigned MAX_LEDS     = 16,
    parameter int unsigned PALETTE_SIZE = 14
) (
    input  logic                 clk,
    input  logic                 rst_n,
    lpbu_item_if.sink            item,
    lpbu_result_if.source        result,
    lpbu_cfg_if.sink             cfg
);

    localparam logic [lpbu_pkg::COUNT_W-1:0] MAX_CNT  = lpbu_pkg::COUNT_W'(MAX_LEDS);
    localparam logic [lpbu_pkg::COLOR_W:0]   PAL_SIZE = (lpbu_pkg::COLOR_W+1)'(PALETTE_SIZE);
    localparam logic [lpbu_pkg::COLOR_W:0]   OFF_IDX  = (lpbu_pkg::COLOR_W+1)'(PALETTE_SIZE - 1);

    lpbu_pkg::state_t state_reg, state_next;

    logic [lpbu_pkg::COLOR_W-1:0]  display_color_reg, internal_color_reg;
    logic [lpbu_pkg::BRIGHT_W-1:0] internal_level_reg;
    logic [lpbu_pkg::MODE_W-1:0]   internal_mode_reg;
    logic [lpbu_pkg::COUNT_W-1:0]  backlight_leds_reg, internal_leds_reg;

    logic [lpbu_pkg::BRIGHT_W-1:0] prev_br_reg, prev_br_next;
    logic [lpbu_pkg::COLOR_W-1:0]  prev_dc_reg, prev_dc_next;
    logic [lpbu_pkg::COLOR_W-1:0]  prev_ic_reg, prev_ic_next;
    logic [lpbu_pkg::BRIGHT_W-1:0] prev_il_reg, prev_il_next;
    logic                          applied_reg, applied_next;

    logic [lpbu_pkg::BRIGHT_W-1:0] br_reg, br_next;
    logic [lpbu_pkg::BRIGHT_W-1:0] lvl_reg, lvl_next;
    logic [lpbu_pkg::COUNT_W-1:0]  nb_reg, nb_next, ni_reg, ni_next;
    logic                          has_color_reg, has_color_next;
    logic                          skip_reg, skip_next;
    logic [2:0]                    step_reg, step_next;
    logic [lpbu_pkg::COUNT_W-1:0]  cnt_reg, cnt_next;
    logic [lpbu_pkg::TOTAL_W-1:0]  total_reg, total_next;
    logic [lpbu_pkg::CHAN_W-1:0]   lev_reg [6];

    logic                          out_valid_reg, out_valid_next;
    logic                          out_kind_reg, out_kind_next;
    logic [lpbu_pkg::INDEX_W-1:0]  out_idx_reg, out_idx_next;
    logic [lpbu_pkg::CHAN_W-1:0]   out_r_reg, out_r_next;
    logic [lpbu_pkg::CHAN_W-1:0]   out_g_reg, out_g_next;
    logic [lpbu_pkg::CHAN_W-1:0]   out_b_reg, out_b_next;
    logic [lpbu_pkg::TOTAL_W-1:0]  out_total_reg, out_total_next;
    logic                          out_last_reg, out_last_next;

    logic                          slot_free;
    logic [lpbu_pkg::COLOR_W-1:0]  calc_color;
    lpbu_pkg::rgb_t                calc_rgb;
    logic [lpbu_pkg::CHAN_W-1:0]   op_p, op_lvl, scaled;
    logic [lpbu_pkg::COUNT_W-1:0]  nb_sat, ni_sat;
    logic [lpbu_pkg::COLOR_W-1:0]  cfg_color;
    logic [lpbu_pkg::COUNT_W:0]    start_pos;
    logic                          changed;

    assign item.ready = (state_reg == lpbu_pkg::S_IDLE);
    assign cfg.ready  = 1'b1;
    assign slot_free  = !out_valid_reg || result.ready;

    assign result.valid     = out_valid_reg;
    assign result.kind      = out_kind_reg;
    assign result.led_index = out_idx_reg;
    assign result.red       = out_r_reg;
    assign result.green     = out_g_reg;
    assign result.blue      = out_b_reg;
    assign result.led_total = out_total_reg;
    assign result.last      = out_last_reg;

    // shared scale unit: one channel level per cycle, product registered inside the unit
    assign calc_color = (step_reg < 3'd3) ? display_color_reg : internal_color_reg;
    assign calc_rgb   = lpbu_pkg::palette_rgb(calc_color);

    always_comb
    begin
        case (step_reg)
            3'd0, 3'd3: op_p = calc_rgb[23:16];
            3'd1, 3'd4: op_p = calc_rgb[15:8];
            3'd2, 3'd5: op_p = calc_rgb[7:0];
            default:    op_p = '0;
        endcase
        if ({1'b0, calc_color} >= OFF_IDX)
        begin
            op_p = '0;
        end
    end

    assign op_lvl = (step_reg < 3'd3) ? br_reg : lvl_reg;

    lpbu_scale u_scale (
        .clk (clk),
        .p   (op_p),
        .lvl (op_lvl),
        .q   (scaled)
    );

    assign nb_sat = (backlight_leds_reg > MAX_CNT) ? MAX_CNT : backlight_leds_reg;
    assign ni_sat = (internal_leds_reg > MAX_CNT) ? MAX_CNT : internal_leds_reg;
    assign start_pos = has_color_reg ? ({1'b0, nb_reg} + {1'b0, cnt_reg})
                                     : {1'b0, cnt_reg};
    assign cfg_color = ({1'b0, cfg.data[3:0]} < PAL_SIZE) ? cfg.data[3:0] : '0;
    assign changed = !applied_reg || (prev_br_reg != br_reg)
                     || (prev_dc_reg != display_color_reg)
                     || (prev_ic_reg != internal_color_reg)
                     || (prev_il_reg != internal_level_reg);

    always_comb
    begin
        state_next     = state_reg;
        prev_br_next   = prev_br_reg;
        prev_dc_next   = prev_dc_reg;
        prev_ic_next   = prev_ic_reg;
        prev_il_next   = prev_il_reg;
        applied_next   = applied_reg;
        br_next        = br_reg;
        lvl_next       = lvl_reg;
        nb_next        = nb_reg;
        ni_next        = ni_reg;
        has_color_next = has_color_reg;
        skip_next      = skip_reg;
        step_next      = step_reg;
        cnt_next       = cnt_reg;
        total_next     = total_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_kind_next  = out_kind_reg;
        out_idx_next   = out_idx_reg;
        out_r_next     = out_r_reg;
        out_g_next     = out_g_reg;
        out_b_next     = out_b_reg;
        out_total_next = out_total_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            lpbu_pkg::S_IDLE:
            begin
                if (item.valid)
                begin
                    br_next    = item.brightness;
                    state_next = lpbu_pkg::S_CHECK;
                end
            end
            lpbu_pkg::S_CHECK:
            begin
                if (!changed)
                begin
                    state_next = lpbu_pkg::S_IDLE;
                end
                else
                begin
                    nb_next        = nb_sat;
                    ni_next        = ni_sat;
                    has_color_next = ({1'b0, display_color_reg} != OFF_IDX);
                    skip_next      = applied_reg && (internal_mode_reg == lpbu_pkg::MODE_ON)
                                     && (prev_ic_reg == internal_color_reg)
                                     && (prev_il_reg == internal_level_reg);
                    lvl_next       = ((internal_mode_reg == lpbu_pkg::MODE_AUTO)
                                      && (br_reg == '0)) ? '0 : internal_level_reg;
                    prev_br_next   = br_reg;
                    prev_dc_next   = display_color_reg;
                    prev_ic_next   = internal_color_reg;
                    prev_il_next   = internal_level_reg;
                    applied_next   = 1'b1;
                    step_next      = '0;
                    cnt_next       = '0;
                    total_next     = '0;
                    state_next     = lpbu_pkg::S_CALC;
                end
            end
            lpbu_pkg::S_CALC:
            begin
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd6)
                begin
                    state_next = lpbu_pkg::S_BACKLIGHT;
                end
            end
            lpbu_pkg::S_BACKLIGHT:
            begin
                if (!has_color_reg || (cnt_reg == nb_reg))
                begin
                    cnt_next   = '0;
                    state_next = lpbu_pkg::S_INTERNAL;
                end
                else if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = lpbu_pkg::KIND_WRITE;
                    out_idx_next   = cnt_reg;
                    out_r_next     = lev_reg[0];
                    out_g_next     = lev_reg[1];
                    out_b_next     = lev_reg[2];
                    out_total_next = '0;
                    out_last_next  = 1'b0;
                    cnt_next       = cnt_reg + 5'd1;
                    total_next     = total_reg + 6'd1;
                end
            end
            lpbu_pkg::S_INTERNAL:
            begin
                if (skip_reg || (cnt_reg == ni_reg))
                begin
                    state_next = lpbu_pkg::S_REFRESH;
                end
                else if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = lpbu_pkg::KIND_WRITE;
                    out_idx_next   = start_pos[lpbu_pkg::INDEX_W-1:0];
                    out_r_next     = lev_reg[3];
                    out_g_next     = lev_reg[4];
                    out_b_next     = lev_reg[5];
                    out_total_next = '0;
                    out_last_next  = 1'b0;
                    cnt_next       = cnt_reg + 5'd1;
                    total_next     = total_reg + 6'd1;
                end
            end
            lpbu_pkg::S_REFRESH:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = lpbu_pkg::KIND_REFRESH;
                    out_idx_next   = '0;
                    out_r_next     = '0;
                    out_g_next     = '0;
                    out_b_next     = '0;
                    out_total_next = total_reg;
                    out_last_next  = 1'b1;
                    state_next     = lpbu_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = lpbu_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= lpbu_pkg::S_IDLE;
            display_color_reg  <= '0;
            internal_color_reg <= '0;
            internal_level_reg <= '0;
            internal_mode_reg  <= lpbu_pkg::MODE_ALWAYS;
            backlight_leds_reg <= lpbu_pkg::BACKLIGHT_RST;
            internal_leds_reg  <= '0;
            prev_br_reg        <= lpbu_pkg::PREV_LEVEL_RST;
            prev_dc_reg        <= lpbu_pkg::PREV_COLOR_RST;
            prev_ic_reg        <= lpbu_pkg::PREV_COLOR_RST;
            prev_il_reg        <= lpbu_pkg::PREV_LEVEL_RST;
            applied_reg        <= 1'b0;
            step_reg           <= '0;
            cnt_reg            <= '0;
            total_reg          <= '0;
            has_color_reg      <= 1'b0;
            skip_reg           <= 1'b0;
            nb_reg             <= '0;
            ni_reg             <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            prev_br_reg   <= prev_br_next;
            prev_dc_reg   <= prev_dc_next;
            prev_ic_reg   <= prev_ic_next;
            prev_il_reg   <= prev_il_next;
            applied_reg   <= applied_next;
            step_reg      <= step_next;
            cnt_reg       <= cnt_next;
            total_reg     <= total_next;
            has_color_reg <= has_color_next;
            skip_reg      <= skip_next;
            nb_reg        <= nb_next;
            ni_reg        <= ni_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                case (cfg.index)
                    lpbu_pkg::REG_DISPLAY_COLOR:  display_color_reg  <= cfg_color;
                    lpbu_pkg::REG_INTERNAL_COLOR: internal_color_reg <= cfg_color;
                    lpbu_pkg::REG_INTERNAL_LEVEL: internal_level_reg <= cfg.data;
                    lpbu_pkg::REG_INTERNAL_MODE:  internal_mode_reg  <= cfg.data[1:0];
                    lpbu_pkg::REG_BACKLIGHT_LEDS: backlight_leds_reg <= cfg.data[4:0];
                    lpbu_pkg::REG_INTERNAL_LEDS:  internal_leds_reg  <= cfg.data[4:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        br_reg        <= br_next;
        lvl_reg       <= lvl_next;
        out_kind_reg  <= out_kind_next;
        out_idx_reg   <= out_idx_next;
        out_r_reg     <= out_r_next;
        out_g_reg     <= out_g_next;
        out_b_reg     <= out_b_next;
        out_total_reg <= out_total_next;
        out_last_reg  <= out_last_next;
        if ((state_reg == lpbu_pkg::S_CALC) && (step_reg != 3'd0))
        begin
            lev_reg[step_reg - 3'd1] <= scaled;
        end
    end

    a_write_no_total: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.kind == lpbu_pkg::KIND_WRITE))
            |-> (result.led_total == '0) && !result.last)
        else $error("LED write beat carries a total or last flag");

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.kind == lpbu_pkg::KIND_REFRESH))
            |-> ({1'b0, result.led_total} <= 7'(2 * MAX_LEDS)))
        else $error("refresh total exceeds two strips of LEDs");

    a_calc_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == lpbu_pkg::S_CALC) && !$past(out_valid_reg)) |-> !out_valid_reg)
        else $error("result loaded while the scale unit is busy");

    a_accept_to_check: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready) |=> (state_reg == lpbu_pkg::S_CHECK) && !item.ready)
        else $error("accepted item not taken to the check step");

endmodule

@@ tb/lpbu_strip_monitor.sv @@
`timescale 1ns / 100ps

module lpbu_strip_monitor
    import lpbu_pkg::*;
#(
    parameter int unsigned MAX_LEDS     = 16,
    parameter int unsigned PALETTE_SIZE = 14
) (
    input  logic        clk,
    input  logic        rst_n,
    lpbu_item_if        item,
    lpbu_result_if      result,
    lpbu_cfg_if         cfg,
    output int unsigned mismatches,
    output int unsigned outstanding
);

    typedef struct packed {
        logic               kind;
        logic [INDEX_W-1:0] led_index;
        logic [CHAN_W-1:0]  red;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  blue;
        logic [TOTAL_W-1:0] led_total;
        logic               last;
    } led_beat_t;

    localparam int unsigned SWATCH_LAST = 12;

    localparam logic [23:0] SWATCH [0:SWATCH_LAST] = '{
        24'hFF4F00, 24'hFFAA00, 24'hA7FF00, 24'h00FF00, 24'h00FF7F,
        24'h00D2D2, 24'h007FFF, 24'h0000FF, 24'h7F00FF, 24'hD200D2,
        24'hFF007F, 24'hFF0000, 24'h8C8C8C
    };

    led_beat_t          expected_beats [$];
    int unsigned        fault_tally;

    logic [COLOR_W-1:0] disp_colour;
    logic [COLOR_W-1:0] int_colour;
    logic [7:0]         int_level;
    logic [MODE_W-1:0]  int_mode;
    logic [COUNT_W-1:0] backlight_count;
    logic [COUNT_W-1:0] internal_count;

    logic [7:0]         applied_bright;
    logic [COLOR_W-1:0] applied_disp;
    logic [COLOR_W-1:0] applied_int_colour;
    logic [7:0]         applied_int_level;
    logic               applied_once;

    function automatic logic [7:0] scale_level(logic [7:0] base, logic [7:0] lvl);
        logic [15:0] prod;
        prod = 16'(base) * 16'(lvl);
        return 8'(prod / 16'd255);
    endfunction

    function automatic int unsigned clamp_count(logic [COUNT_W-1:0] n);
        return (n > MAX_LEDS) ? MAX_LEDS : n;
    endfunction

    function automatic led_beat_t led_write(int unsigned pos, logic [COLOR_W-1:0] colour,
                                            logic [7:0] lvl);
        led_beat_t   b;
        logic [23:0] rgb;
        // off entry, and anything past white, is black
        if (colour < PALETTE_SIZE - 1 && colour <= SWATCH_LAST)
            rgb = SWATCH[colour];
        else
            rgb = 24'd0;
        b.kind      = KIND_WRITE;
        b.led_index = INDEX_W'(pos);
        b.red       = scale_level(rgb[23:16], lvl);
        b.green     = scale_level(rgb[15:8], lvl);
        b.blue      = scale_level(rgb[7:0], lvl);
        b.led_total = '0;
        b.last      = 1'b0;
        return b;
    endfunction

    function automatic void plan_strip(logic [7:0] br);
        int unsigned nb;
        int unsigned ni;
        int unsigned base;
        int unsigned total;
        logic [7:0]  lvl;
        logic        lit;
        logic        skip;
        led_beat_t   refresh;
        if (applied_once && applied_bright == br && applied_disp == disp_colour &&
            applied_int_colour == int_colour && applied_int_level == int_level)
            return;
        nb             = clamp_count(backlight_count);
        ni             = clamp_count(internal_count);
        total          = 0;
        applied_bright = br;
        applied_disp   = disp_colour;
        lit            = (disp_colour != PALETTE_SIZE - 1);
        if (lit)
        begin
            for (int unsigned i = 0; i < nb; i++)
            begin
                expected_beats.push_back(led_write(i, disp_colour, br));
                total++;
            end
        end
        base = lit ? nb : 0;
        skip = applied_once && int_mode == MODE_ON && applied_int_colour == int_colour &&
               applied_int_level == int_level;
        if (!skip)
        begin
            lvl = (int_mode == MODE_AUTO && br == 8'd0) ? 8'd0 : int_level;
            for (int unsigned i = 0; i < ni; i++)
            begin
                expected_beats.push_back(led_write(base + i, int_colour, lvl));
                total++;
            end
        end
        applied_int_colour = int_colour;
        applied_int_level  = int_level;
        applied_once       = 1'b1;
        refresh            = '0;
        refresh.kind       = KIND_REFRESH;
        refresh.led_total  = TOTAL_W'(total);
        refresh.last       = 1'b1;
        expected_beats.push_back(refresh);
    endfunction

    function automatic void take_setting(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_DISPLAY_COLOR:  disp_colour     = (val[3:0] < PALETTE_SIZE) ? val[3:0] : '0;
            REG_INTERNAL_COLOR: int_colour      = (val[3:0] < PALETTE_SIZE) ? val[3:0] : '0;
            REG_INTERNAL_LEVEL: int_level       = val;
            REG_INTERNAL_MODE:  int_mode        = val[MODE_W-1:0];
            REG_BACKLIGHT_LEDS: backlight_count = val[COUNT_W-1:0];
            REG_INTERNAL_LEDS:  internal_count  = val[COUNT_W-1:0];
            default:            ;
        endcase
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fault_tally++;
        end
    endfunction

    function automatic void check_beat();
        led_beat_t want;
        if (expected_beats.size() == 0)
        begin
            $error("result beat with nothing expected: kind %0d led_index %0d",
                   result.kind, result.led_index);
            fault_tally++;
        end
        else
        begin
            want = expected_beats.pop_front();
            check_field("kind", want.kind, result.kind);
            check_field("led_index", want.led_index, result.led_index);
            check_field("red", want.red, result.red);
            check_field("green", want.green, result.green);
            check_field("blue", want.blue, result.blue);
            check_field("led_total", want.led_total, result.led_total);
            check_field("last", want.last, result.last);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_beats.delete();
            fault_tally        = 0;
            disp_colour        = '0;
            int_colour         = '0;
            int_level          = '0;
            int_mode           = MODE_ALWAYS;
            backlight_count    = BACKLIGHT_RST;
            internal_count     = '0;
            applied_bright     = PREV_LEVEL_RST;
            applied_disp       = PREV_COLOR_RST;
            applied_int_colour = PREV_COLOR_RST;
            applied_int_level  = PREV_LEVEL_RST;
            applied_once       = 1'b0;
            mismatches        <= 0;
            outstanding       <= 0;
        end
        else
        begin
            // beats in flight belong to earlier items, so check before planning
            if (result.valid && result.ready)
                check_beat();
            if (cfg.valid && cfg.ready)
                take_setting(cfg.index, cfg.data);
            if (item.valid && item.ready)
                plan_strip(item.brightness);
            mismatches  <= fault_tally;
            outstanding <= expected_beats.size();
        end
    end

endmodule

@@ tb/tb_led_palette_brightness_update_core.sv @@
`timescale 1ns / 100ps

module tb_led_palette_brightness_update_core;
    import lpbu_pkg::*;

    localparam int unsigned MAX_LEDS       = 16;
    localparam int unsigned PALETTE_SIZE   = 14;
    localparam int unsigned RANDOM_ITEMS   = 260;
    localparam int unsigned SETTLE_CYCLES  = 16;
    localparam int unsigned WATCHDOG_LIMIT = 2000;

    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_7 = 3'd7;
    localparam logic [MODE_W-1:0]     MODE_SPARE  = 2'd3;
    localparam logic [7:0]            COLOUR_RED   = 8'd11;
    localparam logic [7:0]            COLOUR_WHITE = 8'd12;
    localparam logic [7:0]            COLOUR_OFF   = 8'd13;

    typedef enum int unsigned {
        STALL_NONE,
        STALL_HALF,
        STALL_HEAVY,
        STALL_RHYTHM
    } stall_style_t;

    logic         clk;
    logic         rst_n;
    int unsigned  beat_errors;
    int unsigned  beats_pending;

    int unsigned  burst_left;
    int unsigned  max_gap;
    int unsigned  items_counted;
    int unsigned  quiet_cycles;
    int unsigned  stall_left;
    int unsigned  ready_tick;
    stall_style_t stall_style;
    logic [7:0]   last_sent;

    lpbu_item_if   item_ch ();
    lpbu_result_if result_ch ();
    lpbu_cfg_if    cfg_ch ();

    led_palette_brightness_update_core #(
        .MAX_LEDS     (MAX_LEDS),
        .PALETTE_SIZE (PALETTE_SIZE)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    lpbu_strip_monitor #(
        .MAX_LEDS     (MAX_LEDS),
        .PALETTE_SIZE (PALETTE_SIZE)
    ) u_strip_monitor (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item_ch),
        .result      (result_ch),
        .cfg         (cfg_ch),
        .mismatches  (beat_errors),
        .outstanding (beats_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_ch.valid && item_ch.ready) ||
            (result_ch.valid && result_ch.ready) || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL led_palette_brightness_update_core");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // result back-pressure in one of four styles, chosen again at random
    always @(posedge clk)
    begin
        ready_tick <= ready_tick + 1;
        if (stall_left == 0)
        begin
            stall_style <= stall_style_t'($urandom_range(0, 3));
            stall_left  <= $urandom_range(4, 64);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_style)
            STALL_NONE:  result_ch.ready <= 1'b1;
            STALL_HALF:  result_ch.ready <= 1'($urandom_range(0, 1));
            STALL_HEAVY: result_ch.ready <= ($urandom_range(0, 3) == 0);
            default:     result_ch.ready <= (ready_tick % 3 != 0);
        endcase
    end

    task automatic send_brightness(logic [7:0] b);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
            if (gap != 0)
            begin
                item_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 8);
        end
        item_ch.valid      <= 1'b1;
        item_ch.brightness <= b;
        do
            @(posedge clk);
        while (!item_ch.ready);
        burst_left--;
        items_counted++;
        last_sent = b;
    endtask

    task automatic drain_strip();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (beats_pending != 0)
            @(posedge clk);
        // unchanged items leave no beat behind, give them time to retire
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
    endtask

    function automatic logic [7:0] pick_colour();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 8'($urandom_range(14, 255));
        else if (r == 1)
            return COLOUR_OFF;
        else
            return 8'($urandom_range(0, 12));
    endfunction

    function automatic logic [7:0] pick_level();
        int unsigned r;
        r = $urandom_range(0, 5);
        if (r == 0)
            return 8'd0;
        else if (r == 1)
            return 8'd255;
        else
            return 8'($urandom);
    endfunction

    function automatic logic [7:0] pick_brightness();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 8'd0;
        else if (r == 1)
            return 8'd255;
        else if (r < 4)
            return last_sent;
        else
            return 8'($urandom);
    endfunction

    task automatic random_settings();
        logic [CFG_ADDR_W-1:0] idx;
        logic [7:0]            val;
        for (int unsigned r = REG_DISPLAY_COLOR; r <= REG_INTERNAL_LEDS; r++)
        begin
            idx = CFG_ADDR_W'(r);
            if ($urandom_range(0, 4) < 3)
            begin
                case (idx)
                    REG_DISPLAY_COLOR, REG_INTERNAL_COLOR:
                        val = pick_colour();
                    REG_INTERNAL_LEVEL:
                        val = pick_level();
                    REG_INTERNAL_MODE:
                        val = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                          : 8'($urandom_range(0, 3));
                    default:
                        val = ($urandom_range(0, 7) == 0) ? 8'($urandom)
                                                          : 8'($urandom_range(0, 5));
                endcase
                write_reg(idx, val);
            end
        end
        cfg_ch.valid <= 1'b0;
    endtask

    initial
    begin
        int unsigned n;
        rst_n               = 1'b0;
        item_ch.valid      <= 1'b0;
        item_ch.brightness <= '0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= '0;
        cfg_ch.data        <= '0;
        burst_left          = 0;
        max_gap             = 4;
        items_counted       = 0;
        last_sent           = PREV_LEVEL_RST;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings; repeat of the same brightness is dropped
        send_brightness(8'd0);
        send_brightness(8'd0);
        send_brightness(8'd255);
        send_brightness(8'd128);
        drain_strip();

        // display off, auto mode, counts over the maximum, spare registers
        write_reg(REG_DISPLAY_COLOR, COLOUR_OFF);
        write_reg(REG_INTERNAL_COLOR, COLOUR_RED);
        write_reg(REG_INTERNAL_LEVEL, 8'd255);
        write_reg(REG_INTERNAL_MODE, 8'(MODE_AUTO));
        write_reg(REG_BACKLIGHT_LEDS, 8'd31);
        write_reg(REG_INTERNAL_LEDS, 8'd31);
        write_reg(REG_SPARE_6, 8'hFF);
        write_reg(REG_SPARE_7, 8'h5A);
        cfg_ch.valid <= 1'b0;
        send_brightness(8'd0);
        send_brightness(8'd255);
        send_brightness(8'd255);
        drain_strip();

        // out-of-range colours, on mode skips unchanged internal settings
        write_reg(REG_DISPLAY_COLOR, 8'd14);
        write_reg(REG_INTERNAL_COLOR, 8'd255);
        write_reg(REG_INTERNAL_LEVEL, 8'd0);
        write_reg(REG_INTERNAL_MODE, 8'(MODE_ON));
        write_reg(REG_BACKLIGHT_LEDS, 8'd16);
        write_reg(REG_INTERNAL_LEDS, 8'd5);
        cfg_ch.valid <= 1'b0;
        send_brightness(8'd77);
        send_brightness(8'd78);
        send_brightness(8'd78);
        drain_strip();

        // mode three, empty strip
        write_reg(REG_INTERNAL_MODE, 8'(MODE_SPARE));
        write_reg(REG_BACKLIGHT_LEDS, 8'd0);
        write_reg(REG_INTERNAL_LEDS, 8'd0);
        write_reg(REG_DISPLAY_COLOR, COLOUR_WHITE);
        write_reg(REG_INTERNAL_COLOR, COLOUR_OFF);
        cfg_ch.valid <= 1'b0;
        send_brightness(8'd1);
        send_brightness(8'd2);
        drain_strip();

        // on mode: a level change alone still rewrites the internal LEDs
        write_reg(REG_INTERNAL_MODE, 8'(MODE_ON));
        write_reg(REG_INTERNAL_LEVEL, 8'd200);
        write_reg(REG_INTERNAL_LEDS, 8'd3);
        write_reg(REG_BACKLIGHT_LEDS, 8'd2);
        write_reg(REG_DISPLAY_COLOR, 8'd5);
        cfg_ch.valid <= 1'b0;
        send_brightness(8'd2);
        send_brightness(8'd2);
        drain_strip();
        write_reg(REG_INTERNAL_LEVEL, 8'd201);
        cfg_ch.valid <= 1'b0;
        send_brightness(8'd2);
        send_brightness(8'd2);
        drain_strip();

        items_counted = 0;
        while (items_counted < RANDOM_ITEMS)
        begin
            random_settings();
            max_gap    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = 0;
            n          = $urandom_range(8, 30);
            repeat (n) send_brightness(pick_brightness());
            drain_strip();
        end

        if (beat_errors == 0)
            $display("PASS led_palette_brightness_update_core");
        else
            $display("FAIL led_palette_brightness_update_core");
        $finish;
    end

endmodule
